@@ hdl/priority_thread_run_queue_unit_assert.svh @@
// Assertion macros shared by the run queue checker.
`ifndef PRIORITY_THREAD_RUN_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_THREAD_RUN_QUEUE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PTRQ_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Implication checked in the cycle after the condition.
`define PTRQ_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

@@ hdl/ptrq_pkg.sv @@
// Package with shared types and codes of the thread run queue.
package ptrq_pkg;
    localparam int MAX_THREADS   = 16;
    localparam int PRIORITY_BITS = 8;

    localparam logic [2:0] ACT_CREATE   = 3'd0;
    localparam logic [2:0] ACT_SET_ST   = 3'd1;
    localparam logic [2:0] ACT_SLEEP    = 3'd2;
    localparam logic [2:0] ACT_STEPPED  = 3'd3;
    localparam logic [2:0] ACT_WAKEUP   = 3'd4;
    localparam logic [2:0] ACT_FINISH   = 3'd5;
    localparam logic [2:0] ACT_SET_PRIO = 3'd6;
    localparam logic [2:0] ACT_UNUSED   = 3'd7;

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_SUSP   = 2'd1;
    localparam logic [1:0] ST_FIN    = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NO_SLOT = 2'd1;
    localparam logic [1:0] STS_UNUSED  = 2'd2;
endpackage

@@ hdl/ptrq_order_cmp.sv @@
// Ordering comparator: does candidate a run before incumbent b.
module ptrq_order_cmp #(
    parameter int PRIORITY_BITS = 8,
    parameter int SLOT_BITS     = 4
) (
    input  logic signed [PRIORITY_BITS-1:0] i_prio_a,
    input  logic        [31:0]              i_stamp_a,
    input  logic        [SLOT_BITS-1:0]     i_slot_a,
    input  logic signed [PRIORITY_BITS-1:0] i_prio_b,
    input  logic        [31:0]              i_stamp_b,
    input  logic        [SLOT_BITS-1:0]     i_slot_b,
    output logic                            o_before
);
    always_comb begin
        if (i_prio_a != i_prio_b) begin
            o_before = i_prio_a > i_prio_b;
        end else if (i_stamp_a != i_stamp_b) begin
            o_before = i_stamp_a < i_stamp_b;
        end else begin
            o_before = i_slot_a < i_slot_b;
        end
    end
endmodule

@@ hdl/priority_thread_run_queue_unit.sv @@
// Top level of the priority thread run queue.
// The block keeps a table of thread slots, each free or holding a thread that
// is running, suspended or finished, and applies one action per input word.
// The input channel (i_valid/o_ready) carries an action with its slot, state,
// priority, key and flags. The output channel (o_valid/i_ready) returns one
// word per action: status, the head of the running list, the created slot,
// the number of threads woken and the latest finish error flag.
// An action that only needs the head scan runs in steps: it is applied, the
// head scan passes every slot, and the result is posted to the output
// register; the next input word is taken only after that post.
// A stepped action on a thread that is not finished adds one peer scan
// before the head scan. A wakeup or an effective finish adds one scan per
// thread woken, plus one scan that finds none unless a single wake or a full
// count of woken threads ends the search first.
// Every scan passes one slot a cycle through the single ordering comparator.
// The input is not ready while an action is in work. A result waits in the
// output register while the receiver stalls; the next action runs meanwhile
// and holds its own result until that register is free. Reset clears every
// slot to free, the stamp counter and the error flag, and leaves the block ready.
module priority_thread_run_queue_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_action,
    input  logic [3:0]        i_thread_slot,
    input  logic [1:0]        i_new_state,
    input  logic signed [7:0] i_priority_req,
    input  logic [15:0]       i_sleep_key,
    input  logic              i_wake_one,
    input  logic              i_error_flag,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic              o_current_valid,
    output logic [3:0]        o_current_thread,
    output logic [3:0]        o_new_thread,
    output logic [4:0]        o_woken_count,
    output logic              o_last_error
);
    localparam int MAX_THREADS = ptrq_pkg::MAX_THREADS;
    localparam int SB = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int PB = ptrq_pkg::PRIORITY_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_APPLY = 3'd1;
    localparam logic [2:0] S_WAKE  = 3'd2;
    localparam logic [2:0] S_HEAD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;

    logic [2:0] r_state, n_state;

    // Slot table; small, each entry read at a scan index or the action slot.
    logic                 r_used  [MAX_THREADS];
    logic [1:0]           r_st    [MAX_THREADS];
    logic signed [PB-1:0] r_prio  [MAX_THREADS];
    logic [15:0]          r_key   [MAX_THREADS];
    logic [31:0]          r_stamp [MAX_THREADS];
    logic [31:0]          r_ctr;
    logic                 r_err;

    // Latched action.
    logic [2:0]           r_act;
    logic [3:0]           r_slot;
    logic [1:0]           r_nst;
    logic signed [PB-1:0] r_preq;
    logic [15:0]          r_wkey;
    logic                 r_one;
    logic                 r_eflag;

    // Scan state.
    logic [SB-1:0] r_idx;
    logic          r_best_ok;
    logic [SB-1:0] r_best;
    logic [4:0]    r_woken;
    logic [1:0]    r_sts;
    logic [3:0]    r_created;
    logic          r_rot;

    logic        r_ovalid;
    logic [1:0]  r_o_sts;
    logic        r_o_cv;
    logic [3:0]  r_o_cur, r_o_new;
    logic [4:0]  r_o_wk;
    logic        r_o_err;

    logic          slot_ok;
    logic [SB-1:0] slot_i;
    logic          cand_before;
    logic          last_idx;
    logic          wake_match, head_match;
    logic          wake_take, wake_bok, wake_stop;
    logic [SB-1:0] wake_bsel;
    logic          step_peer;
    logic          apply_wake, apply_step;
    logic          post_out;

    assign slot_i   = SB'(r_slot);
    assign slot_ok  = ({28'd0, r_slot} < 32'(MAX_THREADS)) && r_used[slot_i];
    assign last_idx = (32'(r_idx) == MAX_THREADS - 1);

    ptrq_order_cmp #(.PRIORITY_BITS(PB), .SLOT_BITS(SB)) u_cmp (
        .i_prio_a  (r_prio[r_idx]),
        .i_stamp_a (r_stamp[r_idx]),
        .i_slot_a  (r_idx),
        .i_prio_b  (r_prio[r_best]),
        .i_stamp_b (r_stamp[r_best]),
        .i_slot_b  (r_best),
        .o_before  (cand_before)
    );

    assign wake_match = r_used[r_idx] && (r_st[r_idx] == ptrq_pkg::ST_SUSP)
                        && (r_key[r_idx] == r_wkey);
    assign head_match = r_used[r_idx] && (r_st[r_idx] == ptrq_pkg::ST_RUN);

    // Wake scan: keep the best sleeper seen so far; stop after one when asked,
    // after a scan that finds none, or once every slot could have been woken.
    assign wake_take = wake_match && (!r_best_ok || cand_before);
    assign wake_bok  = r_best_ok || wake_take;
    assign wake_bsel = wake_take ? r_idx : r_best;
    assign wake_stop = !wake_bok || r_one ||
                       (32'(r_woken) + 32'd1 >= 32'(MAX_THREADS));

    // Peer scan for stepped: the comparator holds the stepped slot as the
    // incumbent, so a peer that does not run before it runs after it.
    assign step_peer = (r_idx != slot_i) && r_used[r_idx] &&
                       (r_st[r_idx] == r_st[slot_i]) &&
                       (r_prio[r_idx] == r_prio[slot_i]) && !cand_before;

    assign apply_wake = (r_act == ptrq_pkg::ACT_WAKEUP) ||
                        ((r_act == ptrq_pkg::ACT_FINISH) && slot_ok &&
                         (r_st[slot_i] != ptrq_pkg::ST_FIN));
    assign apply_step = (r_act == ptrq_pkg::ACT_STEPPED) && slot_ok &&
                        (r_st[slot_i] != ptrq_pkg::ST_FIN);

    // A result posts once the output register is empty or being emptied.
    assign post_out = (r_state == S_OUT) && (!r_ovalid || i_ready);

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_status         = r_o_sts;
    assign o_current_valid  = r_o_cv;
    assign o_current_thread = r_o_cur;
    assign o_new_thread     = r_o_new;
    assign o_woken_count    = r_o_wk;
    assign o_last_error     = r_o_err;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_APPLY;
            S_APPLY: begin
                if (apply_wake) n_state = S_WAKE;
                else if (apply_step) n_state = S_STEP;
                else n_state = S_HEAD;
            end
            S_WAKE:  if (last_idx && wake_stop) n_state = S_HEAD;
            S_STEP:  if (last_idx) n_state = S_HEAD;
            S_HEAD:  if (last_idx) n_state = S_OUT;
            S_OUT:   if (post_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ctr    <= '0;
            r_err    <= 1'b0;
            for (int k = 0; k < MAX_THREADS; k++) begin
                r_used[k]  <= 1'b0;
                r_st[k]    <= ptrq_pkg::ST_RUN;
                r_prio[k]  <= '0;
                r_key[k]   <= '0;
                r_stamp[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (post_out) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_act   <= i_action;
                        r_slot  <= i_thread_slot;
                        r_nst   <= i_new_state;
                        r_preq  <= PB'(i_priority_req);
                        r_wkey  <= i_sleep_key;
                        r_one   <= i_wake_one;
                        r_eflag <= i_error_flag;
                    end
                    r_woken   <= '0;
                    r_sts     <= ptrq_pkg::STS_OK;
                    r_created <= '0;
                    r_idx     <= '0;
                    r_best_ok <= 1'b0;
                    r_best    <= '0;
                    r_rot     <= 1'b0;
                end
                S_APPLY: begin
                    r_idx     <= '0;
                    r_best_ok <= 1'b0;
                    if (r_act == ptrq_pkg::ACT_CREATE) begin
                        logic          found;
                        logic [SB-1:0] pick;
                        found = 1'b0;
                        pick  = '0;
                        for (int k = MAX_THREADS - 1; k >= 0; k--) begin
                            if (!r_used[k] || r_st[k] == ptrq_pkg::ST_FIN) begin
                                found = 1'b1;
                                pick  = SB'(k);
                            end
                        end
                        if (!found) begin
                            r_sts <= ptrq_pkg::STS_NO_SLOT;
                        end else begin
                            r_used[pick] <= 1'b1;
                            r_prio[pick] <= '0;
                            r_key[pick]  <= '0;
                            r_st[pick]   <= r_eflag ? ptrq_pkg::ST_FIN : ptrq_pkg::ST_RUN;
                            if (!r_eflag) begin
                                r_stamp[pick] <= r_ctr;
                                r_ctr         <= r_ctr + 32'd1;
                            end
                            r_created <= 4'(pick);
                        end
                    end else if (r_act != ptrq_pkg::ACT_WAKEUP &&
                                 r_act != ptrq_pkg::ACT_UNUSED) begin
                        if (!slot_ok) begin
                            r_sts <= ptrq_pkg::STS_UNUSED;
                        end else begin
                            case (r_act)
                                ptrq_pkg::ACT_SET_ST: begin
                                    if (r_nst != ptrq_pkg::ST_UNUSED &&
                                        r_nst != r_st[slot_i]) begin
                                        if (r_st[slot_i] == ptrq_pkg::ST_SUSP &&
                                            r_nst == ptrq_pkg::ST_RUN)
                                            r_woken <= 5'd1;
                                        r_st[slot_i] <= r_nst;
                                        if (r_nst != ptrq_pkg::ST_FIN) begin
                                            r_stamp[slot_i] <= r_ctr;
                                            r_ctr <= r_ctr + 32'd1;
                                        end
                                    end
                                end
                                ptrq_pkg::ACT_SLEEP: begin
                                    r_prio[slot_i] <= r_preq;
                                    r_key[slot_i]  <= r_wkey;
                                    if (r_st[slot_i] != ptrq_pkg::ST_SUSP) begin
                                        r_st[slot_i]    <= ptrq_pkg::ST_SUSP;
                                        r_stamp[slot_i] <= r_ctr;
                                        r_ctr <= r_ctr + 32'd1;
                                    end
                                end
                                ptrq_pkg::ACT_STEPPED: begin
                                    // The peer scan compares every slot against this one.
                                    r_best <= slot_i;
                                end
                                ptrq_pkg::ACT_FINISH: begin
                                    if (r_st[slot_i] != ptrq_pkg::ST_FIN) begin
                                        r_st[slot_i] <= ptrq_pkg::ST_FIN;
                                        r_err  <= r_eflag;
                                        r_wkey <= {12'd0, r_slot};
                                        r_one  <= 1'b0;
                                    end
                                end
                                ptrq_pkg::ACT_SET_PRIO: begin
                                    if (r_preq != r_prio[slot_i]) begin
                                        r_prio[slot_i] <= r_preq;
                                        if (r_st[slot_i] != ptrq_pkg::ST_FIN) begin
                                            r_stamp[slot_i] <= r_ctr;
                                            r_ctr <= r_ctr + 32'd1;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_WAKE: begin
                    if (last_idx) begin
                        r_idx     <= '0;
                        r_best_ok <= 1'b0;
                        r_best    <= '0;
                        if (wake_bok) begin
                            r_key[wake_bsel]   <= '0;
                            r_st[wake_bsel]    <= ptrq_pkg::ST_RUN;
                            r_stamp[wake_bsel] <= r_ctr;
                            r_ctr   <= r_ctr + 32'd1;
                            r_woken <= r_woken + 5'd1;
                        end
                    end else begin
                        r_idx     <= r_idx + SB'(1);
                        r_best_ok <= wake_bok;
                        r_best    <= wake_bsel;
                    end
                end
                S_STEP: begin
                    if (last_idx) begin
                        r_idx     <= '0;
                        r_best_ok <= 1'b0;
                        r_best    <= '0;
                        if (r_rot || step_peer) begin
                            r_stamp[slot_i] <= r_ctr;
                            r_ctr <= r_ctr + 32'd1;
                        end
                    end else begin
                        r_idx <= r_idx + SB'(1);
                        r_rot <= r_rot || step_peer;
                    end
                end
                S_HEAD: begin
                    if (head_match && (!r_best_ok || cand_before)) begin
                        r_best_ok <= 1'b1;
                        r_best    <= r_idx;
                    end
                    if (!last_idx) r_idx <= r_idx + SB'(1);
                end
                S_OUT: begin
                    if (post_out) begin
                        r_o_sts <= r_sts;
                        r_o_cv  <= r_best_ok;
                        r_o_cur <= r_best_ok ? 4'(r_best) : 4'd0;
                        r_o_new <= r_created;
                        r_o_wk  <= r_woken;
                        r_o_err <= r_err;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ hdl/ptrq_checker.sv @@
// Port checker for the run queue, bound to the top level.
`include "priority_thread_run_queue_unit_assert.svh"
module ptrq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic       o_current_valid,
    input logic [3:0] o_current_thread,
    input logic [4:0] o_woken_count
);
    `PTRQ_ASSERT_NEXT(a_hold_while_stalled, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `PTRQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `PTRQ_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, o_status <= ptrq_pkg::STS_UNUSED)
    `PTRQ_ASSERT_IMP(a_idle_thread_zero, i_clk, i_rst_n, o_valid && !o_current_valid,
        o_current_thread == 4'd0)
    `PTRQ_ASSERT_IMP(a_woken_bound, i_clk, i_rst_n, o_valid, o_woken_count <= 5'd16)
endmodule

bind priority_thread_run_queue_unit ptrq_checker u_ptrq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_current_valid  (o_current_valid),
    .o_current_thread (o_current_thread),
    .o_woken_count    (o_woken_count)
);
